// ===== rtl/brz_pkg.sv =====
// Package for the line rasterizer: coordinate and register widths, reset values,
// the function and register index codes. No dependencies.
package brz_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_W          = 13;
    localparam int COLOR_W        = 32;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Function code carried in the input tuser.
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

endpackage

// ===== rtl/bresenham_line_rasterizer.sv =====
// Bresenham line stepper with frame clipping flag, one pixel per beat.
// Depends on brz_pkg for widths, reset values and codes.
//
// Usage:
//   A slave beat with tuser = start latches two endpoints and a color, sets up
//   the line along its major axis and returns the first pixel. Each slave beat
//   with tuser = advance returns the next pixel; after the pixel marked with
//   tlast the line is done, and a further advance returns a beat with the
//   valid flag in m_tuser low and all other fields zero. A start during a line
//   drops the old line. Every slave beat gives exactly one master beat.
//   The result of a beat accepted at a clock edge is shown on the master side
//   right after that edge. Throughput is one beat per cycle; the stepper state
//   and the output register are updated in the same cycle. A stall on the
//   master side holds the output register, and the slave side takes one new
//   beat only when that register is empty or being drained. The user must
//   write frame width and height through the plain write port only while the
//   block is idle; the block does not enforce it. Reset clears the line state,
//   empties the output register and sets the frame to 640 by 480.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = brz_pkg::COORD_BITS_DEF,
    localparam int IN_W  = 4 * COORD_BITS + brz_pkg::COLOR_W,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = 2 * COORD_BITS + brz_pkg::COLOR_W,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write port.
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [brz_pkg::CFG_W-1:0] cfg_wr_data,
    // Slave side.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TW-1:0]          s_tdata,   // start_x, start_y, end_x, end_y, line_color
    input  logic [0:0]                s_tuser,   // func
    // Master side.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TW-1:0]         m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic [1:0]                m_tuser,   // pixel_valid, inside_res
    output logic                      m_tlast
);

    localparam int CB   = COORD_BITS;
    localparam int EW   = CB + 3;
    localparam int CMPW = (CB > brz_pkg::CFG_W) ? CB : brz_pkg::CFG_W;
    localparam int CLW  = brz_pkg::COLOR_W;

    // Configuration registers.
    logic [brz_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= brz_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= brz_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                brz_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                brz_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Line state.
    logic                 active_reg, active_next;
    logic                 steep_reg, steep_next;
    logic signed [CB-1:0] major_pos_reg, major_pos_next;
    logic signed [CB-1:0] major_end_reg, major_end_next;
    logic signed [CB-1:0] minor_pos_reg, minor_pos_next;
    logic                 minor_neg_reg, minor_neg_next;
    logic [CB:0]          major_delta_reg, major_delta_next;
    logic [CB+1:0]        error_step_reg, error_step_next;
    logic signed [EW-1:0] error_acc_reg, error_acc_next;
    logic [CLW-1:0]       held_color_reg, held_color_next;

    // Output register.
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_TW-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    logic in_beat;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    // Slave payload fields.
    logic signed [CB-1:0] in_x0, in_y0, in_x1, in_y1;
    logic [CLW-1:0]       in_color;
    logic                 is_start;

    assign in_x0    = s_tdata[CB-1:0];
    assign in_y0    = s_tdata[2*CB-1:CB];
    assign in_x1    = s_tdata[3*CB-1:2*CB];
    assign in_y1    = s_tdata[4*CB-1:3*CB];
    assign in_color = s_tdata[4*CB+CLW-1:4*CB];
    assign is_start = (s_tuser[0] == brz_pkg::FUNC_START);

    // Line setup for a start beat.
    logic signed [CB:0]   dx, dy, dm;
    logic [CB:0]          adx, ady, adm;
    logic                 st_steep, st_swap;
    logic signed [CB-1:0] a0, a1, b0, b1;
    logic signed [CB-1:0] st_major_pos, st_major_end, st_minor_pos, st_minor_end;
    logic signed [CB:0]   st_delta_s;

    always_comb begin
        dx       = {in_x1[CB-1], in_x1} - {in_x0[CB-1], in_x0};
        dy       = {in_y1[CB-1], in_y1} - {in_y0[CB-1], in_y0};
        adx      = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
        ady      = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
        // Equal deltas keep x as the major axis.
        st_steep = adx < ady;
        a0 = st_steep ? in_y0 : in_x0;
        a1 = st_steep ? in_y1 : in_x1;
        b0 = st_steep ? in_x0 : in_y0;
        b1 = st_steep ? in_x1 : in_y1;
        st_swap      = a0 > a1;
        st_major_pos = st_swap ? a1 : a0;
        st_major_end = st_swap ? a0 : a1;
        st_minor_pos = st_swap ? b1 : b0;
        st_minor_end = st_swap ? b0 : b1;
        st_delta_s   = {st_major_end[CB-1], st_major_end}
                     - {st_major_pos[CB-1], st_major_pos};
        dm  = {st_minor_end[CB-1], st_minor_end} - {st_minor_pos[CB-1], st_minor_pos};
        adm = dm[CB] ? $unsigned(-dm) : $unsigned(dm);
    end

    // Current line values: freshly set up on a start, else the stored state.
    logic                 cur_steep, cur_minor_neg;
    logic signed [CB-1:0] cur_major, cur_end, cur_minor;
    logic [CB:0]          cur_delta;
    logic [CB+1:0]        cur_step;
    logic signed [EW-1:0] cur_acc;
    logic [CLW-1:0]       cur_color;

    always_comb begin
        if (is_start) begin
            cur_steep     = st_steep;
            cur_major     = st_major_pos;
            cur_end       = st_major_end;
            cur_minor     = st_minor_pos;
            cur_minor_neg = st_minor_end < st_minor_pos;
            cur_delta     = $unsigned(st_delta_s);
            cur_step      = {adm, 1'b0};
            cur_acc       = '0;
            cur_color     = in_color;
        end else begin
            cur_steep     = steep_reg;
            cur_major     = major_pos_reg;
            cur_end       = major_end_reg;
            cur_minor     = minor_pos_reg;
            cur_minor_neg = minor_neg_reg;
            cur_delta     = major_delta_reg;
            cur_step      = error_step_reg;
            cur_acc       = error_acc_reg;
            cur_color     = held_color_reg;
        end
    end

    // Pixel emission and one Bresenham step.
    logic signed [CB-1:0] px, py;
    logic                 is_last, in_x, in_y, minor_move;
    logic signed [EW-1:0] acc_sum, delta_s;

    always_comb begin
        px      = cur_steep ? cur_minor : cur_major;
        py      = cur_steep ? cur_major : cur_minor;
        is_last = (cur_major == cur_end);
        in_x    = !px[CB-1] && (CMPW'($unsigned(px)) < CMPW'(frame_width_reg));
        in_y    = !py[CB-1] && (CMPW'($unsigned(py)) < CMPW'(frame_height_reg));
        delta_s    = $signed({2'b00, cur_delta});
        acc_sum    = cur_acc + $signed({1'b0, cur_step});
        minor_move = acc_sum > delta_s;
    end

    // Next state.
    always_comb begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        minor_neg_next   = minor_neg_reg;
        major_delta_next = major_delta_reg;
        error_step_next  = error_step_reg;
        error_acc_next   = error_acc_reg;
        held_color_next  = held_color_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        if (in_beat) begin
            m_tvalid_next = 1'b1;
            if (is_start || active_reg) begin
                m_tdata_next = OUT_TW'({cur_color, py, px});
                m_tuser_next = {in_x && in_y, 1'b1};
                m_tlast_next = is_last;

                active_next      = !is_last;
                steep_next       = cur_steep;
                major_end_next   = cur_end;
                minor_neg_next   = cur_minor_neg;
                major_delta_next = cur_delta;
                error_step_next  = cur_step;
                held_color_next  = cur_color;
                if (is_last) begin
                    major_pos_next = cur_major;
                    minor_pos_next = cur_minor;
                    error_acc_next = cur_acc;
                end else begin
                    major_pos_next = cur_major + CB'(1);
                    if (minor_move) begin
                        minor_pos_next = cur_minor_neg ? cur_minor - CB'(1)
                                                       : cur_minor + CB'(1);
                        error_acc_next = acc_sum - (delta_s <<< 1);
                    end else begin
                        minor_pos_next = cur_minor;
                        error_acc_next = acc_sum;
                    end
                end
            end else begin
                // Advance with no line: an empty pixel beat.
                m_tdata_next = '0;
                m_tuser_next = '0;
                m_tlast_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            minor_neg_reg   <= 1'b0;
            major_delta_reg <= '0;
            error_step_reg  <= '0;
            error_acc_reg   <= '0;
            held_color_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            active_reg      <= active_next;
            steep_reg       <= steep_next;
            major_pos_reg   <= major_pos_next;
            major_end_reg   <= major_end_next;
            minor_pos_reg   <= minor_pos_next;
            minor_neg_reg   <= minor_neg_next;
            major_delta_reg <= major_delta_next;
            error_step_reg  <= error_step_next;
            error_acc_reg   <= error_acc_next;
            held_color_reg  <= held_color_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
